// ===== rtl/core/dsdc_pkg.sv =====
// Package for the day serial date converter: word types, calendar constants and
// the month length function.
// No dependencies.
package dsdc_pkg;

    // Years covered, counted from the base year
    localparam int YEAR_SPAN  = 256;
    localparam int BASE_YEAR  = 1970;
    localparam int LAST_YEAR  = BASE_YEAR + YEAR_SPAN - 1;
    localparam int SERIAL_MAX = 131071;

    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SERIAL_W = 17;

    // The accumulator holds a whole span of years plus a year of months
    localparam int ACC_RAW_W = $clog2(YEAR_SPAN * 366 + 12 * 31 + 1);
    localparam int ACC_W     = (ACC_RAW_W > SERIAL_W) ? ACC_RAW_W : SERIAL_W;

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    typedef struct packed {
        logic                action;
        logic [YEAR_W-1:0]   year_in;
        logic [MONTH_W-1:0]  month_in;
        logic [DAY_W-1:0]    day_in;
        logic [SERIAL_W-1:0] serial_in;
    } req_word_t;

    typedef struct packed {
        logic [SERIAL_W-1:0] serial_out;
        logic [YEAR_W-1:0]   year_out;
        logic [MONTH_W-1:0]  month_out;
        logic [DAY_W-1:0]    day_out;
        logic                ok;
    } rsp_word_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/day_serial_date_converter.sv =====
// Top level of the day serial date converter: sequencer, shared add/subtract
// unit, calendar counters and result register.
// Depends on dsdc_pkg.
//
// Converts between a calendar date and a day serial (1 January 1970 is day 1),
// Gregorian leap rule throughout, years 1970 to 1970+YEAR_SPAN-1. One word is
// taken at a time: req_stall stays high from acceptance until the result is
// parked in the output register, which then waits for the consumer while the
// next request may already be taken. The walk is done by the single
// add/subtract unit, which walks one year or one month per cycle. A failed
// conversion returns an all-zero word, ok included; checks on the year and
// month fields and on a zero serial cost no walk, while the day is checked at
// the end of the month walk.
module day_serial_date_converter
    import dsdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_word_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_YEARS  = 4'b0010,
        ST_MONTHS = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    localparam logic [YEAR_W-1:0] BASE_Y = YEAR_W'(BASE_YEAR);
    localparam logic [YEAR_W-1:0] LAST_Y = YEAR_W'(LAST_YEAR);

    state_t              state_reg, state_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_reg, rsp_next;

    // Latched request
    logic                action_reg, action_next;
    logic [YEAR_W-1:0]   year_tgt_reg, year_tgt_next;
    logic [MONTH_W-1:0]  month_tgt_reg, month_tgt_next;
    logic [DAY_W-1:0]    day_tgt_reg, day_tgt_next;

    // Walk state: running year, month, running serial, leap counters
    logic [YEAR_W-1:0]   y_reg, y_next;
    logic [MONTH_W-1:0]  m_reg, m_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [6:0]          mod100_reg, mod100_next;   // year mod 100
    logic [1:0]          cent_reg, cent_next;       // century mod 4
    logic                ok_reg, ok_next;

    logic                leap;
    logic [8:0]          year_len;
    logic [DAY_W-1:0]    mon_len;
    logic                at_tgt_month;
    logic [ACC_W-1:0]    opd;
    logic [ACC_W-1:0]    alu_res;
    logic                acc_le_opd;
    logic                req_fail;

    assign leap     = (y_reg[1:0] == 2'd0) && ((mod100_reg != 7'd0) || (cent_reg == 2'd0));
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mon_len  = month_len(m_reg, leap);
    assign at_tgt_month = (m_reg == month_tgt_reg);

    // Shared unit: add on encode, subtract on decode, plus a compare
    always_comb
    begin
        if (state_reg == ST_MONTHS)
        begin
            if (action_reg == ACT_ENCODE && at_tgt_month)
                opd = ACC_W'(day_tgt_reg);
            else
                opd = ACC_W'(mon_len);
        end
        else
        begin
            opd = ACC_W'(year_len);
        end
    end

    assign alu_res    = (action_reg == ACT_DECODE) ? (acc_reg - opd) : (acc_reg + opd);
    assign acc_le_opd = (acc_reg <= opd);

    always_comb
    begin
        if (req.action == ACT_DECODE)
            req_fail = (req.serial_in == '0);
        else
            req_fail = (req.year_in < BASE_Y) || (req.year_in > LAST_Y) ||
                       (req.month_in == 4'd0) || (req.month_in > 4'd12);
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        action_next    = action_reg;
        year_tgt_next  = year_tgt_reg;
        month_tgt_next = month_tgt_reg;
        day_tgt_next   = day_tgt_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        acc_next       = acc_reg;
        mod100_next    = mod100_reg;
        cent_next      = cent_reg;
        ok_next        = ok_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    action_next    = req.action;
                    year_tgt_next  = req.year_in;
                    month_tgt_next = req.month_in;
                    day_tgt_next   = req.day_in;
                    y_next         = BASE_Y;
                    m_next         = 4'd1;
                    mod100_next    = 7'(BASE_YEAR % 100);
                    cent_next      = 2'((BASE_YEAR / 100) % 4);
                    acc_next       = (req.action == ACT_DECODE) ? ACC_W'(req.serial_in) : '0;
                    ok_next        = !req_fail;
                    state_next     = req_fail ? ST_DONE : ST_YEARS;
                end
            end

            ST_YEARS:
            begin
                if (action_reg == ACT_ENCODE && y_reg == year_tgt_reg)
                begin
                    state_next = ST_MONTHS;
                end
                else if (action_reg == ACT_DECODE && y_reg > LAST_Y)
                begin
                    ok_next    = 1'b0;           // serial past the span
                    state_next = ST_DONE;
                end
                else if (action_reg == ACT_DECODE && acc_le_opd)
                begin
                    state_next = ST_MONTHS;
                end
                else
                begin
                    acc_next = alu_res;
                    y_next   = y_reg + 1'b1;
                    if (mod100_reg == 7'd99)
                    begin
                        mod100_next = 7'd0;
                        cent_next   = cent_reg + 1'b1;
                    end
                    else
                    begin
                        mod100_next = mod100_reg + 1'b1;
                    end
                end
            end

            ST_MONTHS:
            begin
                if (action_reg == ACT_ENCODE)
                begin
                    if (at_tgt_month)
                    begin
                        acc_next   = alu_res;
                        ok_next    = (day_tgt_reg != '0) && (day_tgt_reg <= mon_len) &&
                                     (alu_res <= ACC_W'(SERIAL_MAX));
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        acc_next = alu_res;
                        m_next   = m_reg + 1'b1;
                    end
                end
                else if (m_reg == 4'd12 || acc_le_opd)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    acc_next = alu_res;
                    m_next   = m_reg + 1'b1;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next = '0;
                    if (ok_reg)
                    begin
                        rsp_next.ok = 1'b1;
                        if (action_reg == ACT_ENCODE)
                        begin
                            rsp_next.serial_out = acc_reg[SERIAL_W-1:0];
                        end
                        else
                        begin
                            rsp_next.year_out  = y_reg;
                            rsp_next.month_out = m_reg;
                            rsp_next.day_out   = acc_reg[DAY_W-1:0];
                        end
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg       <= rsp_next;
        action_reg    <= action_next;
        year_tgt_reg  <= year_tgt_next;
        month_tgt_reg <= month_tgt_next;
        day_tgt_reg   <= day_tgt_next;
        y_reg         <= y_next;
        m_reg         <= m_next;
        acc_reg       <= acc_next;
        mod100_reg    <= mod100_next;
        cent_reg      <= cent_next;
        ok_reg        <= ok_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A failed word is all zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.ok) |-> (rsp == '0))
        else $error("failed result word not cleared");

    // A good decode always lands on a real month
    a_decode_month: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.ok && rsp.serial_out == '0) |->
        (rsp.month_out >= 4'd1 && rsp.month_out <= 4'd12 && rsp.day_out != '0))
        else $error("decoded month or day out of range");

    // An accepted word starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("sequencer idle after accept");

    // Year walk never runs past one year beyond the span
    a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_YEARS) |-> (y_reg <= LAST_Y + 1'b1))
        else $error("year walk overran the span");

    // Month counter stays within the year
    a_month_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MONTHS) |-> (m_reg >= 4'd1 && m_reg <= 4'd12))
        else $error("month walk out of range");

endmodule

// ===== tb/day_serial_date_converter_test.sv =====
// Self-checking bench for day_serial_date_converter: directed table, then
// random words under five load phases, each checked against a table entry or the predictor.
// Depends on dsdc_pkg and the converter RTL.
`timescale 1ns / 1ps

module day_serial_date_converter_test;
    import dsdc_pkg::*;

    // Load phases: idling on the request side, stalling on the result side
    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_HOLD
    } load_phase_t;

    // One word to send, with its expected result where it is written out
    typedef struct {
        req_word_t word;
        bit        fixed;
        rsp_word_t result;
    } date_case_t;

    localparam rsp_word_t FAILED_WORD     = '0;
    localparam int        PHASE_WORDS     = 140;
    localparam int        HOLD_STALL      = 150; // long receiver hold-off
    localparam int        HOLD_GAP        = 25;
    localparam int        DRAIN_CYCLES    = 300; // quiet run after the last result
    localparam int        WATCHDOG_LIMIT  = 5000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_word_t req       = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp;

    load_phase_t phase = PH_FREE;

    date_case_t directed_cases[$];
    date_case_t outgoing_requests[$];
    rsp_word_t  pending_results[$];
    date_case_t on_bus;            // word currently offered on req

    int last_serial;               // serial of 31 December of the last year
    int n_accepted     = 0;
    int n_checked      = 0;
    int n_encoded      = 0;
    int n_decoded      = 0;
    int n_refused      = 0;
    int n_errors       = 0;
    int stall_run      = 0;
    int longest_stall  = 0;
    int hold_tick      = 0;
    int quiet_cycles   = 0;

    day_serial_date_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Calendar predictor
    // ---------------------------------------------------------------

    // Full Gregorian rule: centuries are leap only when divisible by 400
    function automatic bit is_leap_year(int y);
        if (y % 400 == 0)
            return 1'b1;
        if (y % 100 == 0)
            return 1'b0;
        return (y % 4) == 0;
    endfunction

    function automatic int year_days(int y);
        return is_leap_year(y) ? 366 : 365;
    endfunction

    function automatic int month_days(int y, int m);
        case (m)
            2:             return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Result word for one request; any refusal yields an all-zero word
    function automatic rsp_word_t calendar_result(req_word_t w);
        rsp_word_t r;
        int yr, mo, dy, s, y, m, walked;
        r  = '0;
        yr = w.year_in;
        mo = w.month_in;
        dy = w.day_in;
        if (w.action == ACT_ENCODE)
        begin
            if (yr < BASE_YEAR || yr > LAST_YEAR)
                return r;
            if (mo < 1 || mo > 12)
                return r;
            if (dy == 0 || dy > month_days(yr, mo))
                return r;
            s = dy;
            for (m = 1; m < mo; m++)
                s += month_days(yr, m);
            for (y = BASE_YEAR; y < yr; y++)
                s += year_days(y);
            if (s > SERIAL_MAX)
                return r;
            r.serial_out = SERIAL_W'(s);
            r.ok         = 1'b1;
            return r;
        end
        s = w.serial_in;
        if (s == 0)
            return r;
        y      = BASE_YEAR;
        walked = 0;
        while (walked < YEAR_SPAN && s > year_days(y))
        begin
            s -= year_days(y);
            y++;
            walked++;
        end
        if (walked >= YEAR_SPAN)
            return r;
        m = 1;
        while (m < 12 && s > month_days(y, m))
        begin
            s -= month_days(y, m);
            m++;
        end
        r.year_out  = YEAR_W'(y);
        r.month_out = MONTH_W'(m);
        r.day_out   = DAY_W'(s);
        r.ok        = 1'b1;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic req_word_t make_req(logic act, int y, int m, int d, int s);
        req_word_t w;
        w.action    = act;
        w.year_in   = YEAR_W'(y);
        w.month_in  = MONTH_W'(m);
        w.day_in    = DAY_W'(d);
        w.serial_in = SERIAL_W'(s);
        return w;
    endfunction

    function automatic rsp_word_t make_rsp(int s, int y, int m, int d);
        rsp_word_t r;
        r.serial_out = SERIAL_W'(s);
        r.year_out   = YEAR_W'(y);
        r.month_out  = MONTH_W'(m);
        r.day_out    = DAY_W'(d);
        r.ok         = 1'b1;
        return r;
    endfunction

    // fixed = 0: the predictor supplies the expectation on acceptance
    task automatic add_case(req_word_t w, bit fixed, rsp_word_t r);
        date_case_t c;
        c.word   = w;
        c.fixed  = fixed;
        c.result = r;
        directed_cases.push_back(c);
    endtask

    // Mostly well-formed dates and in-span serials, the rest raw noise.
    // Fields the action ignores keep their random bits.
    function automatic date_case_t random_case();
        date_case_t c;
        int roll, y, m, len;
        c.fixed  = 1'b0;
        c.result = '0;
        c.word   = req_word_t'({$urandom, $urandom});
        roll     = $urandom_range(99);
        if (c.word.action == ACT_ENCODE)
        begin
            if (roll < 82)
            begin
                // short walks for most words, whole span and centuries now and then
                case ($urandom_range(9))
                    0:       y = 2000 + 100 * $urandom_range(2);
                    1, 2:    y = $urandom_range(LAST_YEAR, BASE_YEAR);
                    default: y = $urandom_range(BASE_YEAR + 40, BASE_YEAR);
                endcase
                m   = $urandom_range(12, 1);
                len = month_days(y, m);
                c.word.year_in  = YEAR_W'(y);
                c.word.month_in = MONTH_W'(m);
                case ($urandom_range(9))
                    0:       c.word.day_in = DAY_W'(len + 1);
                    1:       c.word.day_in = DAY_W'(len);
                    2:       c.word.day_in = (m == 2) ? DAY_W'(29) : DAY_W'(len);
                    default: c.word.day_in = DAY_W'($urandom_range(len, 1));
                endcase
            end
            else if (roll < 88)
                c.word.year_in = YEAR_W'($urandom_range(LAST_YEAR + 3, BASE_YEAR - 3));
        end
        else
        begin
            if (roll < 80)
                c.word.serial_in = SERIAL_W'($urandom_range(last_serial, 1));
            else if (roll < 90)
                c.word.serial_in = ($urandom_range(1) == 0) ?
                    SERIAL_W'($urandom_range(40, 0)) :
                    SERIAL_W'($urandom_range(last_serial + 40, last_serial - 40));
        end
        return c;
    endfunction

    function automatic int send_idle_pct(load_phase_t p);
        case (p)
            PH_SEND_IDLE: return 71;
            PH_BOTH:      return 22;
            default:      return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(load_phase_t p);
        case (p)
            PH_RECV_STALL: return 71;
            PH_BOTH:       return 22;
            default:       return 0;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Request side: one nonblocking write per signal per edge. A new
    // word is only put up once the previous one has been taken.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                pending_results.push_back(on_bus.fixed ? on_bus.result
                                                       : calendar_result(on_bus.word));
                n_accepted++;
            end
            // longest run of a word waiting at a stalled input
            if (req_valid && req_stall)
            begin
                stall_run++;
                if (stall_run > longest_stall)
                    longest_stall = stall_run;
            end
            else
                stall_run = 0;
            if (!req_valid || !req_stall)
            begin
                if (outgoing_requests.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct(phase))
                begin
                    on_bus     = outgoing_requests.pop_front();
                    req       <= on_bus.word;
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result side stall. In the hold phase the receiver sits stalled for
    // a long stretch, then lets a few words out, and repeats; the sender
    // keeps offering so the converter fills and backs up its input.
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (phase == PH_HOLD)
        begin
            rsp_stall <= hold_tick < HOLD_STALL;
            hold_tick  = (hold_tick + 1) % (HOLD_STALL + HOLD_GAP);
        end
        else
            rsp_stall <= $urandom_range(99) < recv_stall_pct(phase);
    end

    // ---------------------------------------------------------------
    // Result checking, oldest expectation first
    // ---------------------------------------------------------------
    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, rsp);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("serial_out", want.serial_out, rsp.serial_out);
                check_field("year_out",   want.year_out,   rsp.year_out);
                check_field("month_out",  want.month_out,  rsp.month_out);
                check_field("day_out",    want.day_out,    rsp.day_out);
                check_field("ok",         want.ok,         rsp.ok);
                n_checked++;
                if (!want.ok)
                    n_refused++;
                else if (want.month_out == 0)
                    n_encoded++;
                else
                    n_decoded++;
            end
        end
    end

    // Watchdog: too long with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog, no handshake for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_results.size());
                $display("day_serial_date_converter_test: errors");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        date_case_t  c;
        load_phase_t p;
        int          y;

        last_serial = 0;
        for (y = BASE_YEAR; y <= LAST_YEAR; y++)
            last_serial += year_days(y);

        // Directed table: span edges, bad fields, leap rule, serial edges
        add_case(make_req(ACT_ENCODE, 1970, 1, 1, 0), 1, make_rsp(1, 0, 0, 0));
        add_case(make_req(ACT_ENCODE, 1969, 12, 31, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, LAST_YEAR, 12, 31, 0), 0, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, LAST_YEAR + 1, 1, 1, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 4095, 15, 31, 131071), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 0, 0, 0, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 1970, 0, 1, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 1970, 13, 1, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 1970, 1, 0, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 1970, 4, 31, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 1970, 12, 31, 0), 1, make_rsp(365, 0, 0, 0));
        add_case(make_req(ACT_ENCODE, 1972, 2, 29, 0), 0, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 1971, 2, 29, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 2000, 2, 29, 0), 0, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 2100, 2, 29, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_ENCODE, 1970, 1, 31, 131071), 1, make_rsp(31, 0, 0, 0));
        add_case(make_req(ACT_DECODE, 0, 0, 0, 0), 1, FAILED_WORD);
        add_case(make_req(ACT_DECODE, 0, 0, 0, 1), 1, make_rsp(0, 1970, 1, 1));
        add_case(make_req(ACT_DECODE, 0, 0, 0, 365), 1, make_rsp(0, 1970, 12, 31));
        add_case(make_req(ACT_DECODE, 0, 0, 0, 366), 1, make_rsp(0, 1971, 1, 1));
        add_case(make_req(ACT_DECODE, 4095, 15, 31, 60), 0, FAILED_WORD);
        add_case(make_req(ACT_DECODE, 0, 0, 0, 11017), 0, FAILED_WORD);
        add_case(make_req(ACT_DECODE, 0, 0, 0, last_serial), 1,
                 make_rsp(0, LAST_YEAR, 12, 31));
        add_case(make_req(ACT_DECODE, 0, 0, 0, last_serial + 1), 1, FAILED_WORD);
        add_case(make_req(ACT_DECODE, 0, 0, 0, 131071), 1, FAILED_WORD);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_cases[i])
            outgoing_requests.push_back(directed_cases[i]);
        while (outgoing_requests.size() > 0)
            @(negedge clk);

        // Random words, one batch per load phase. Phase changes happen on
        // the falling edge so the drivers never see them mid-edge.
        for (int k = PH_FREE; k <= PH_HOLD; k++)
        begin
            p     = load_phase_t'(k);
            phase = p;
            repeat (PHASE_WORDS)
            begin
                c = random_case();
                outgoing_requests.push_back(c);
            end
            while (outgoing_requests.size() > 0)
                @(negedge clk);
        end

        while (req_valid || pending_results.size() > 0)
            @(negedge clk);
        phase = PH_FREE;
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d of %0d words: %0d encodes, %0d decodes, %0d refused.",
                 n_checked, n_accepted, n_encoded, n_decoded, n_refused);
        $display("Five load phases incl. a long output hold-off; input stalled up to %0d cycles.",
                 longest_stall);
        if (n_errors == 0)
            $display("day_serial_date_converter_test: clean");
        else
            $display("day_serial_date_converter_test: errors");
        $finish;
    end

endmodule
